// File: hdl/svfp_pkg.sv
// Package for the sampled-values frame parser: beat types, parse phase codes,
// per-frame parser state and the single-byte parse step functions.
// No dependencies.
`default_nettype none

package svfp_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned EndW          = 17;  // width of frame positions and end marks

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [11:0] frame_length;
  } in_beat_t;

  typedef struct packed {
    logic               sample_valid;
    logic signed [31:0] sample_value;
    logic [7:0]         channel_index;
    logic [7:0]         asdu_index;
    logic               frame_end;
    logic [1:0]         frame_status;
  } out_beat_t;

  typedef struct packed {
    logic [47:0] stream_mac;
    logic [47:0] filter_mac;
    logic        filter_enable;
    logic        analyzer_enable;
  } cfg_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegStreamMac = 2'd0;
  localparam logic [1:0] RegFilterMac = 2'd1;
  localparam logic [1:0] RegFiltEn    = 2'd2;
  localparam logic [1:0] RegAnaEn     = 2'd3;

  // Frame status codes.
  localparam logic [1:0] StatParsed  = 2'd0;
  localparam logic [1:0] StatIgnored = 2'd1;
  localparam logic [1:0] StatBad     = 2'd2;

  // Parse phases.
  localparam logic [4:0] PH_IDLE         = 5'd0;
  localparam logic [4:0] PH_HDR          = 5'd1;
  localparam logic [4:0] PH_SKIP_HDR     = 5'd2;
  localparam logic [4:0] PH_LEN_A        = 5'd3;
  localparam logic [4:0] PH_LEN_B        = 5'd4;
  localparam logic [4:0] PH_LEN_C        = 5'd5;
  localparam logic [4:0] PH_NOASDU_TAG   = 5'd6;
  localparam logic [4:0] PH_NOASDU_VAL   = 5'd7;
  localparam logic [4:0] PH_AFTER_NOASDU = 5'd8;
  localparam logic [4:0] PH_SKIP_SEC     = 5'd9;
  localparam logic [4:0] PH_AFTER_SEC    = 5'd10;
  localparam logic [4:0] PH_ASDU_TAG     = 5'd11;
  localparam logic [4:0] PH_FTAG         = 5'd12;
  localparam logic [4:0] PH_FLEN_A       = 5'd13;
  localparam logic [4:0] PH_FLEN_B       = 5'd14;
  localparam logic [4:0] PH_FLEN_C       = 5'd15;
  localparam logic [4:0] PH_FSKIP        = 5'd16;
  localparam logic [4:0] PH_SAMPLES      = 5'd17;
  localparam logic [4:0] PH_ASDU_TAIL    = 5'd18;
  localparam logic [4:0] PH_DONE         = 5'd19;
  localparam logic [4:0] PH_STOP         = 5'd20;

  // Tag and header byte values.
  localparam logic [7:0] TagEthHi   = 8'h88;
  localparam logic [7:0] TagEthLo   = 8'hBA;
  localparam logic [7:0] TagSavPdu  = 8'h60;
  localparam logic [7:0] TagLen2    = 8'h82;
  localparam logic [7:0] TagLen1    = 8'h81;
  localparam logic [7:0] TagNoAsdu  = 8'h80;
  localparam logic [7:0] TagSec     = 8'h81;
  localparam logic [7:0] TagSeqAsdu = 8'hA2;
  localparam logic [7:0] TagAsdu    = 8'h30;
  localparam logic [7:0] TagSeqData = 8'h87;
  localparam logic [7:0] TagVlanHi  = 8'h81;
  localparam logic [7:0] TagVlanLo  = 8'h00;

  typedef struct packed {
    logic [4:0]      ph;
    logic [47:0]     mac;
    logic [2:0]      flags;   // stream match, source match, destination match
    logic [15:0]     lacc;
    logic [EndW-1:0] aend;
    logic [7:0]      arem;
    logic [7:0]      acnt;
    logic [7:0]      ftag;
    logic [EndW-1:0] send;
    logic [12:0]     srem;
    logic [31:0]     ssh;
    logic [2:0]      sbc;
    logic [7:0]      ch;
    logic [1:0]      err;
  } pst_t;

  typedef struct packed {
    pst_t        s;
    logic        done;
    logic [15:0] len;
  } ber_t;

  typedef struct packed {
    pst_t        s;
    logic        again;
    logic        sv;
    logic [31:0] val;
    logic [7:0]  ch;
    logic [7:0]  asdu;
  } disp_t;

  function automatic pst_t stop_with(pst_t si, logic [1:0] code);
    pst_t s;
    s = si;
    s.err = code;
    s.ph  = PH_STOP;
    return s;
  endfunction

  // One byte of a BER length starting at phase base.
  function automatic ber_t ber_step(pst_t si, logic [7:0] b, logic [4:0] base);
    ber_t r;
    r      = '0;
    r.s    = si;
    if (si.ph == base) begin
      if (b == TagLen2) begin
        r.s.lacc = '0;
        r.s.ph   = base + 5'd1;
      end else if (b == TagLen1) begin
        r.s.lacc = '0;
        r.s.ph   = base + 5'd2;
      end else begin
        r.done = 1'b1;
        r.len  = {8'h00, b};
      end
    end else if (si.ph == base + 5'd1) begin
      r.s.lacc = {b, 8'h00};
      r.s.ph   = base + 5'd2;
    end else begin
      r.done = 1'b1;
      r.len  = si.lacc | {8'h00, b};
    end
    return r;
  endfunction

  function automatic pst_t eth_seen(pst_t si, logic [7:0] hi, logic [7:0] lo,
                                    logic [EndW-1:0] p, cfg_t c);
    pst_t s;
    s = si;
    if (hi != TagEthHi || lo != TagEthLo || !c.analyzer_enable || !si.flags[2]) begin
      s = stop_with(si, StatIgnored);
    end else begin
      s.send = p + EndW'(9);
      s.ph   = PH_SKIP_HDR;
    end
    return s;
  endfunction

  // One dispatch of byte b at position p; again asks for a second dispatch.
  function automatic disp_t dispatch(pst_t si, logic [7:0] b, logic [EndW-1:0] p,
                                     logic [EndW-1:0] eff, cfg_t c);
    disp_t           r;
    ber_t            br;
    logic [EndW-1:0] nxt;
    logic [EndW-1:0] endp;
    logic [47:0]     m;
    r   = '0;
    r.s = si;
    nxt = p + EndW'(1);
    case (si.ph)
      PH_HDR: begin
        if (p < EndW'(12)) begin
          m = {si.mac[39:0], b};
          r.s.mac = m;
          if (p == EndW'(5) && m == c.filter_mac) r.s.flags[0] = 1'b1;
          if (p == EndW'(11)) begin
            if (m == c.filter_mac) r.s.flags[1] = 1'b1;
            if (m == c.stream_mac) r.s.flags[2] = 1'b1;
            if (c.filter_enable && !(r.s.flags[0] || r.s.flags[1])) begin
              r.s = stop_with(r.s, StatIgnored);
            end
          end
        end else if (p == EndW'(12) || p == EndW'(16)) begin
          r.s.ftag = b;
        end else if (p == EndW'(13)) begin
          if (!(si.ftag == TagVlanHi && b == TagVlanLo)) r.s = eth_seen(si, si.ftag, b, p, c);
        end else if (p == EndW'(17)) begin
          r.s = eth_seen(si, si.ftag, b, p, c);
        end
      end
      PH_SKIP_HDR: begin
        if (p >= si.send) begin
          if (b == TagSavPdu) begin
            r.s.ftag = TagSavPdu;
            r.s.ph   = PH_LEN_A;
          end else begin
            r.s = stop_with(si, StatBad);
          end
        end
      end
      PH_LEN_A, PH_LEN_B, PH_LEN_C: begin
        br  = ber_step(si, b, PH_LEN_A);
        r.s = br.s;
        endp = nxt + EndW'(br.len);
        if (br.done) begin
          if (si.ftag == TagSavPdu) begin
            if (endp > eff) r.s = stop_with(br.s, StatBad);
            else r.s.ph = PH_NOASDU_TAG;
          end else if (si.ftag == TagSec) begin
            r.s.send = endp;
            r.s.ph   = PH_SKIP_SEC;
          end else if (si.ftag == TagSeqAsdu) begin
            r.s.ph = PH_ASDU_TAG;
          end else begin
            r.s.aend = endp;
            r.s.ph   = PH_FTAG;
          end
        end
      end
      PH_NOASDU_TAG: begin
        if (b == TagNoAsdu) r.s.ph = PH_NOASDU_VAL;
        else r.s = stop_with(si, StatBad);
      end
      PH_NOASDU_VAL: begin
        r.s.arem = b;
        r.s.acnt = '0;
        r.s.ph   = (b != 8'h00) ? PH_AFTER_NOASDU : PH_DONE;
      end
      PH_AFTER_NOASDU: begin
        if (b == TagSec) begin
          r.s.ftag = TagSec;
          r.s.ph   = PH_LEN_A;
        end else begin
          r.s.ph  = PH_AFTER_SEC;
          r.again = 1'b1;
        end
      end
      PH_SKIP_SEC: begin
        if (p >= si.send) begin
          r.s.ph  = PH_AFTER_SEC;
          r.again = 1'b1;
        end
      end
      PH_AFTER_SEC: begin
        if (b == TagSeqAsdu) begin
          r.s.ftag = TagSeqAsdu;
          r.s.ph   = PH_LEN_A;
        end else begin
          r.s.ph  = PH_ASDU_TAG;
          r.again = 1'b1;
        end
      end
      PH_ASDU_TAG: begin
        if (b == TagAsdu) begin
          r.s.ftag = TagAsdu;
          r.s.ph   = PH_LEN_A;
        end else begin
          r.s = stop_with(si, StatBad);
        end
      end
      PH_FTAG, PH_ASDU_TAIL: begin
        if (p >= si.aend) begin
          r.s.acnt = si.acnt + 8'd1;
          r.s.arem = si.arem - 8'd1;
          r.s.ph   = (si.arem != 8'd1) ? PH_ASDU_TAG : PH_DONE;
          r.again  = 1'b1;
        end else if (si.ph == PH_FTAG) begin
          r.s.ftag = b;
          r.s.ph   = PH_FLEN_A;
        end
      end
      PH_FLEN_A, PH_FLEN_B, PH_FLEN_C: begin
        br   = ber_step(si, b, PH_FLEN_A);
        r.s  = br.s;
        endp = nxt + EndW'(br.len);
        if (br.done) begin
          if (endp > si.aend) begin
            r.s = stop_with(br.s, StatBad);
          end else if (si.ftag == TagSeqData) begin
            r.s.srem = br.len[15:3];
            r.s.ch   = '0;
            r.s.sbc  = '0;
            r.s.ph   = (br.len[15:3] != 13'd0) ? PH_SAMPLES : PH_ASDU_TAIL;
          end else begin
            r.s.send = endp;
            r.s.ph   = PH_FSKIP;
          end
        end
      end
      PH_FSKIP: begin
        if (p >= si.send) begin
          r.s.ph  = PH_FTAG;
          r.again = 1'b1;
        end
      end
      PH_SAMPLES: begin
        if (si.sbc == 3'd0 && (p + EndW'(8)) > eff) begin
          r.s = stop_with(si, StatBad);
        end else begin
          if (si.sbc < 3'd4) r.s.ssh = {si.ssh[23:0], b};
          if (si.sbc == 3'd3) begin
            r.sv   = 1'b1;
            r.val  = r.s.ssh;
            r.ch   = si.ch;
            r.asdu = si.acnt;
            r.s.ch = si.ch + 8'd1;
          end
          if (si.sbc == 3'd7) begin
            r.s.sbc  = '0;
            r.s.srem = si.srem - 13'd1;
            if (si.srem == 13'd1) r.s.ph = PH_ASDU_TAIL;
          end else begin
            r.s.sbc = si.sbc + 3'd1;
          end
        end
      end
      default: begin
        r.s = si;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/svfp_core.sv
// Parse core of the sampled-values frame parser: frame state registers and
// the per-byte step logic. Depends on svfp_pkg.
`default_nettype none

module svfp_core #(
  parameter int unsigned MAX_FRAME_BYTES = svfp_pkg::MaxFrameBytes
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  svfp_pkg::in_beat_t    beat_i,
  input  svfp_pkg::cfg_t        cfg_i,
  output logic                  res_valid_o,
  output svfp_pkg::out_beat_t   res_o
);
  import svfp_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);
  localparam logic [EndW-1:0] EffMax = EndW'(MAX_FRAME_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  pst_t            st_q, st_d;

  logic [EndW-1:0] len_ext, eff, p;
  pst_t            s0;
  disp_t           r0, r1, r2, r3;
  logic            run, sv_any;
  logic [1:0]      status;

  assign len_ext = EndW'(beat_i.frame_length);
  assign eff     = (len_ext > EffMax) ? EffMax : len_ext;
  assign run     = beat_i.first_byte || (st_q.ph != PH_IDLE);

  always_comb begin
    s0 = st_q;
    if (beat_i.first_byte) begin
      s0    = '0;
      s0.ph = PH_HDR;
    end
  end

  assign p = beat_i.first_byte ? '0 : EndW'(pos_q);

  // Up to four dispatches per byte: a phase may hand the byte to the next one.
  always_comb begin
    r0 = dispatch(s0, beat_i.data_byte, p, eff, cfg_i);
    r1 = r0;
    r2 = r0;
    r3 = r0;
    if (r0.again) r1 = dispatch(r0.s, beat_i.data_byte, p, eff, cfg_i);
    r2 = r1;
    if (r0.again && r1.again) r2 = dispatch(r1.s, beat_i.data_byte, p, eff, cfg_i);
    r3 = r2;
    if (r0.again && r1.again && r2.again) begin
      r3 = dispatch(r2.s, beat_i.data_byte, p, eff, cfg_i);
    end
  end

  always_comb begin
    st_d   = s0;
    sv_any = 1'b0;
    if (p < eff) begin
      st_d   = r3.s;
      sv_any = r3.sv;
    end
    status = StatParsed;
    if (st_d.ph == PH_DONE) status = StatParsed;
    else if (st_d.ph == PH_STOP) status = st_d.err;
    else status = StatBad;
    if (beat_i.last_byte) st_d.ph = PH_IDLE;
    pos_d = (p < EndW'(PosMax)) ? PosW'(p + EndW'(1)) : PosMax;
  end

  always_comb begin
    res_valid_o = run && (sv_any || beat_i.last_byte);
    res_o       = '0;
    if (sv_any) begin
      res_o.sample_valid  = 1'b1;
      res_o.sample_value  = r3.val;
      res_o.channel_index = r3.ch;
      res_o.asdu_index    = r3.asdu;
    end
    res_o.frame_end = beat_i.last_byte;
    if (beat_i.last_byte) res_o.frame_status = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      st_q  <= '0;
    end else if (step_i && run) begin
      pos_q <= pos_d;
      st_q  <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sampled_values_frame_parser_unit.sv
// Top level of the sampled-values frame parser: configuration registers,
// input beat register, parse core and output beat register. Depends on
// svfp_pkg and svfp_core.
//
// The parser takes one Ethernet frame byte per beat and accepts a new beat
// in every cycle unless stalled, so it keeps up with a gigabit receive path.
// Each byte passes an input register, then the parse core whose combinational
// step (the byte may pass through up to four parse phases) ends in the output
// register. A beat out comes either when a 32-bit sample completes (value,
// channel and ASDU index) or on the frame's last byte, which carries
// frame_status: 0 parsed, 1 ignored by the MAC filter, stream MAC, ethertype
// or a disabled analyzer, 2 malformed or truncated. When the output is
// stalled the input register holds one more byte and then the input stalls
// too. The four registers sit on the APB port at byte addresses 0, 8, 16
// and 24 (64-bit data); write them only while no frame is in flight.
`default_nettype none

module sampled_values_frame_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = svfp_pkg::MaxFrameBytes
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  svfp_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output svfp_pkg::out_beat_t  out_data_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [4:0]           paddr,
  input  wire  [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import svfp_pkg::*;

  cfg_t      cfg_q;
  logic      in_vld_q;
  in_beat_t  in_q;
  logic      out_vld_q;
  out_beat_t out_q;
  logic      adv, res_valid;
  out_beat_t res;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        RegStreamMac: cfg_q.stream_mac      <= pwdata[47:0];
        RegFilterMac: cfg_q.filter_mac      <= pwdata[47:0];
        RegFiltEn:    cfg_q.filter_enable   <= pwdata[0];
        RegAnaEn:     cfg_q.analyzer_enable <= pwdata[0];
        default:      cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegStreamMac: prdata = {16'h0000, cfg_q.stream_mac};
      RegFilterMac: prdata = {16'h0000, cfg_q.filter_mac};
      RegFiltEn:    prdata = {63'd0, cfg_q.filter_enable};
      RegAnaEn:     prdata = {63'd0, cfg_q.analyzer_enable};
      default:      prdata = '0;
    endcase
  end

  // The core advances whenever the output register is empty or being taken.
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
  end

  svfp_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_vld_q && adv),
    .beat_i      (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hdl/svfp_checker.sv
// Port-level checks for the sampled-values frame parser and the bind that
// attaches them to the top level. Depends on svfp_pkg.
`default_nettype none

module svfp_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input svfp_pkg::out_beat_t out_data_o,
  input wire                 pready
);
  import svfp_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Sample fields are zero on a beat without a sample.
  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sample_valid |->
      out_data_o.sample_value == 0 && out_data_o.channel_index == 8'd0 &&
      out_data_o.asdu_index == 8'd0)
    else $error("sample fields set without a sample");

  // Status is zero off the frame end and never an unused code.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.frame_end || out_data_o.frame_status == StatParsed) &&
      out_data_o.frame_status != 2'd3)
    else $error("bad frame status");

  // A result beat carries either a sample or a frame end.
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sample_valid || out_data_o.frame_end)
    else $error("empty result beat");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind sampled_values_frame_parser_unit svfp_checker u_svfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

`default_nettype wire

// File: tb/sv/tb_sampled_values_frame_parser_unit.sv
// Self-checking testbench for sampled_values_frame_parser_unit: random and directed
// sampled-value frames, an inline frame predictor and a result scoreboard.
// Depends on svfp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_sampled_values_frame_parser_unit;
  import svfp_pkg::*;

  localparam int unsigned FrameCap   = 2048;
  localparam int unsigned CycleLimit = 400000;

  // The scoreboard carries its own copy of the parser state. Every accepted
  // input beat is run through the same byte walk the parser performs, and the
  // beat it should produce (if any) is queued for comparison.
  class sv_frame_scoreboard;
    out_beat_t   sample_q[$];
    int          errors;
    logic [47:0] strm_mac, filt_mac;
    bit          filt_en, ana_en;
    int          pos, asdu_end, skip_end;
    logic [4:0]  phase;
    logic [47:0] mac_sr;
    bit          dst_hit, src_hit, strm_hit;
    logic [15:0] len_acc;
    logic [7:0]  asdu_left, asdu_num, tag, chan;
    logic [12:0] entries_left;
    logic [31:0] shift;
    logic [2:0]  nbyte;
    logic [1:0]  err;
    bit          smp_v;
    logic [31:0] smp_val;
    logic [7:0]  smp_ch, smp_asdu;

    function void set_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
        RegStreamMac: strm_mac = v[47:0];
        RegFilterMac: filt_mac = v[47:0];
        RegFiltEn:    filt_en  = v[0];
        default:      ana_en   = v[0];
      endcase
    endfunction

    function void clear_frame();
      pos = 0; phase = PH_IDLE; mac_sr = '0; dst_hit = 0; src_hit = 0; strm_hit = 0;
      len_acc = '0; asdu_end = 0; asdu_left = '0; asdu_num = '0; tag = '0;
      skip_end = 0; entries_left = '0; shift = '0; nbyte = '0; chan = '0; err = '0;
    endfunction

    function void halt(logic [1:0] code);
      err = code;
      phase = PH_STOP;
    endfunction

    // BER length walk; returns 1 once the length is complete.
    function bit ber_take(logic [7:0] b, logic [4:0] base, output int len);
      len = 0;
      if (phase == base) begin
        if (b == TagLen2) begin
          len_acc = '0; phase = base + 5'd1; return 0;
        end
        if (b == TagLen1) begin
          len_acc = '0; phase = base + 5'd2; return 0;
        end
        len = b;
        return 1;
      end
      if (phase == base + 5'd1) begin
        len_acc = {b, 8'h00};
        phase = base + 5'd2;
        return 0;
      end
      len = len_acc | {8'h00, b};
      return 1;
    endfunction

    function void next_asdu();
      asdu_num++;
      asdu_left--;
      phase = (asdu_left != 0) ? PH_ASDU_TAG : PH_DONE;
    endfunction

    function void eth_check(logic [7:0] hi, logic [7:0] lo, int p);
      if (hi != TagEthHi || lo != TagEthLo || !ana_en || !strm_hit) begin
        halt(StatIgnored);
      end else begin
        skip_end = p + 9;
        phase = PH_SKIP_HDR;
      end
    endfunction

    // One pass over byte b at position p; 1 means the byte is looked at again.
    function bit walk(logic [7:0] b, int p, int eff);
      int len;
      int stop_at;
      case (phase)
        PH_HDR: begin
          if (p < 12) begin
            mac_sr = {mac_sr[39:0], b};
            if (p == 5 && mac_sr == filt_mac) dst_hit = 1;
            if (p == 11) begin
              if (mac_sr == filt_mac) src_hit = 1;
              if (mac_sr == strm_mac) strm_hit = 1;
              if (filt_en && !(dst_hit || src_hit)) halt(StatIgnored);
            end
          end else if (p == 12 || p == 16) begin
            tag = b;
          end else if (p == 13) begin
            if (!(tag == TagVlanHi && b == TagVlanLo)) eth_check(tag, b, p);
          end else if (p == 17) begin
            eth_check(tag, b, p);
          end
        end
        PH_SKIP_HDR: begin
          if (p >= skip_end) begin
            if (b == TagSavPdu) begin
              tag = TagSavPdu; phase = PH_LEN_A;
            end else begin
              halt(StatBad);
            end
          end
        end
        PH_LEN_A, PH_LEN_B, PH_LEN_C: begin
          if (ber_take(b, PH_LEN_A, len)) begin
            stop_at = p + 1 + len;
            if (tag == TagSavPdu) begin
              if (stop_at > eff) halt(StatBad);
              else phase = PH_NOASDU_TAG;
            end else if (tag == TagSec) begin
              skip_end = stop_at; phase = PH_SKIP_SEC;
            end else if (tag == TagSeqAsdu) begin
              phase = PH_ASDU_TAG;
            end else begin
              asdu_end = stop_at; phase = PH_FTAG;
            end
          end
        end
        PH_NOASDU_TAG: begin
          if (b == TagNoAsdu) phase = PH_NOASDU_VAL;
          else halt(StatBad);
        end
        PH_NOASDU_VAL: begin
          asdu_left = b;
          asdu_num = '0;
          phase = (b != 0) ? PH_AFTER_NOASDU : PH_DONE;
        end
        PH_AFTER_NOASDU: begin
          if (b == TagSec) begin
            tag = TagSec; phase = PH_LEN_A;
          end else begin
            phase = PH_AFTER_SEC; return 1;
          end
        end
        PH_SKIP_SEC: begin
          if (p >= skip_end) begin
            phase = PH_AFTER_SEC; return 1;
          end
        end
        PH_AFTER_SEC: begin
          if (b == TagSeqAsdu) begin
            tag = TagSeqAsdu; phase = PH_LEN_A;
          end else begin
            phase = PH_ASDU_TAG; return 1;
          end
        end
        PH_ASDU_TAG: begin
          if (b == TagAsdu) begin
            tag = TagAsdu; phase = PH_LEN_A;
          end else begin
            halt(StatBad);
          end
        end
        PH_FTAG: begin
          if (p >= asdu_end) begin
            next_asdu(); return 1;
          end
          tag = b;
          phase = PH_FLEN_A;
        end
        PH_FLEN_A, PH_FLEN_B, PH_FLEN_C: begin
          if (ber_take(b, PH_FLEN_A, len)) begin
            stop_at = p + 1 + len;
            if (stop_at > asdu_end) begin
              halt(StatBad);
            end else if (tag == TagSeqData) begin
              entries_left = 13'(len >> 3);
              chan = '0;
              nbyte = '0;
              phase = (entries_left != 0) ? PH_SAMPLES : PH_ASDU_TAIL;
            end else begin
              skip_end = stop_at; phase = PH_FSKIP;
            end
          end
        end
        PH_FSKIP: begin
          if (p >= skip_end) begin
            phase = PH_FTAG; return 1;
          end
        end
        PH_SAMPLES: begin
          if (nbyte == 0 && p + 8 > eff) begin
            halt(StatBad);
            return 0;
          end
          if (nbyte < 4) shift = {shift[23:0], b};
          if (nbyte == 3) begin
            smp_v = 1; smp_val = shift; smp_ch = chan; smp_asdu = asdu_num;
            chan++;
          end
          if (nbyte == 7) begin
            nbyte = '0;
            entries_left--;
            if (entries_left == 0) phase = PH_ASDU_TAIL;
          end else begin
            nbyte++;
          end
        end
        PH_ASDU_TAIL: begin
          if (p >= asdu_end) begin
            next_asdu(); return 1;
          end
        end
        default: ;
      endcase
      return 0;
    endfunction

    // Runs one accepted input beat through the predictor.
    function void note_input(in_beat_t d);
      int eff;
      int p;
      out_beat_t e;
      eff = (d.frame_length > FrameCap) ? FrameCap : d.frame_length;
      if (d.first_byte) begin
        clear_frame();
        phase = PH_HDR;
      end else if (phase == PH_IDLE) begin
        return;
      end
      smp_v = 0;
      p = pos;
      if (p < eff)
        for (int k = 0; k < 4; k++)
          if (!walk(d.data_byte, p, eff)) break;
      pos = (p < FrameCap) ? p + 1 : FrameCap;
      e = '0;
      if (d.last_byte) begin
        if (phase == PH_DONE) e.frame_status = StatParsed;
        else if (phase == PH_STOP) e.frame_status = err;
        else e.frame_status = StatBad;
        e.frame_end = 1'b1;
        phase = PH_IDLE;
      end
      if (!smp_v && !d.last_byte) return;
      if (smp_v) begin
        e.sample_valid = 1'b1;
        e.sample_value = smp_val;
        e.channel_index = smp_ch;
        e.asdu_index = smp_asdu;
      end
      sample_q.insert(sample_q.size(), e);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t e;
      if (sample_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat out: %p", got);
        return;
      end
      e = sample_q.pop_front();
      if (got.sample_valid !== e.sample_valid || got.sample_value !== e.sample_value ||
          got.channel_index !== e.channel_index || got.asdu_index !== e.asdu_index ||
          got.frame_end !== e.frame_end || got.frame_status !== e.frame_status) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, actual %p", e, got);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_beat_t    in_data_i;
  out_beat_t   out_data_o;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;

  sampled_values_frame_parser_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
    .out_data_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sv_frame_scoreboard sb;
  int   cycles;
  int   burst_left;
  int   sent_bytes;
  bit   hold_req;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Both monitors sample before any of this edge's stimulus updates land.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_sampled_values_frame_parser_unit: errors");
      $finish;
    end
  end

  // Receiver back-pressure. The stall mode changes whenever its random run
  // length ends; mode 0 never stalls. A requested hold keeps the output
  // stalled so the parser fills up and has to stall its input.
  initial begin
    int mode;
    int left;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(64, 256);
      end
      left--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= cycles[0];
      endcase
    end
  end

  // APB write: setup cycle, then the access cycle that commits the register.
  task automatic reg_write(logic [1:0] idx, logic [63:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offers one beat, inserting a random gap when the current burst runs out,
  // and returns at the edge where the parser takes it.
  task automatic send_beat(logic [7:0] b, bit first, bit last, logic [11:0] flen);
    in_beat_t d;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 400 : $urandom_range(1, 40);
    end
    burst_left--;
    d.data_byte = b; d.first_byte = first; d.last_byte = last; d.frame_length = flen;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    sent_bytes++;
  endtask

  task automatic play(logic [7:0] q[$], logic [11:0] flen, bit drop_last);
    foreach (q[i]) send_beat(q[i], i == 0, (i == q.size() - 1) && !drop_last, flen);
  endtask

  // Waits until every predicted beat has come out, then lets the pipeline
  // empty, so the registers can be rewritten with nothing in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.sample_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Appends one byte to a frame under construction.
  function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
    q.insert(q.size(), v);
  endfunction

  function automatic void put_len(ref logic [7:0] q[$], input int n);
    int f;
    f = $urandom_range(0, 2);
    if (n > 255) f = 2;
    else if (n > 127 && f == 0) f = 1;
    case (f)
      0: add_byte(q, n[7:0]);
      1: begin add_byte(q, TagLen1); add_byte(q, n[7:0]); end
      default: begin add_byte(q, TagLen2); add_byte(q, n[15:8]); add_byte(q, n[7:0]); end
    endcase
  endfunction

  function automatic void put_mac(ref logic [7:0] q[$], input logic [47:0] m);
    for (int i = 5; i >= 0; i--) add_byte(q, m[8*i +: 8]);
  endfunction

  function automatic logic [47:0] pick_mac(int pref);
    int r;
    r = $urandom_range(0, 9);
    if (r < pref) return sb.strm_mac;
    if (r < 8) return sb.filt_mac;
    if (r == 8) return 48'hFFFF_FFFF_FFFF;
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  // Builds a frame with random content (rarely a wrong ethertype): header, optional
  // VLAN tag, SAVPDU with optional security and seqASDU wrapper, then nasdu ASDUs.
  function automatic void build_frame(ref logic [7:0] f[$], input int nasdu);
    logic [7:0] pdu[$], asdu[$], body[$];
    int n, nf;
    f.delete();
    put_mac(f, pick_mac(3));
    put_mac(f, pick_mac(7));
    if ($urandom_range(0, 3) == 0) begin
      add_byte(f, TagVlanHi); add_byte(f, TagVlanLo);
      add_byte(f, 8'($urandom)); add_byte(f, 8'($urandom));
    end
    if ($urandom_range(0, 19) == 0) begin
      add_byte(f, 8'($urandom)); add_byte(f, 8'($urandom));
    end else begin
      add_byte(f, TagEthHi); add_byte(f, TagEthLo);
    end
    repeat (8) add_byte(f, 8'($urandom));
    add_byte(pdu, TagNoAsdu);
    add_byte(pdu, nasdu[7:0]);
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(0, 6);
      add_byte(pdu, TagSec);
      put_len(pdu, n);
      repeat (n) add_byte(pdu, 8'($urandom));
    end
    for (int a = 0; a < nasdu; a++) begin
      asdu.delete();
      nf = $urandom_range(0, 2);
      repeat (nf) begin
        n = $urandom_range(0, 6);
        add_byte(asdu, 8'($urandom_range(8'h80, 8'h86)));
        put_len(asdu, n);
        repeat (n) add_byte(asdu, 8'($urandom));
      end
      n = 8 * $urandom_range(0, 6) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0);
      add_byte(asdu, TagSeqData);
      put_len(asdu, n);
      repeat (n) add_byte(asdu, 8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        add_byte(asdu, 8'h88); add_byte(asdu, 8'h01); add_byte(asdu, 8'($urandom));
      end
      add_byte(body, TagAsdu);
      put_len(body, asdu.size());
      body = {body, asdu};
    end
    if ($urandom_range(0, 2) == 0) begin
      add_byte(pdu, TagSeqAsdu);
      put_len(pdu, body.size());
    end
    pdu = {pdu, body};
    add_byte(f, TagSavPdu);
    put_len(f, pdu.size());
    f = {f, pdu};
  endfunction

  // One random frame: mostly clean, the rest corrupted, truncated, given a
  // wrong length, or abandoned by the next frame's first byte.
  task automatic random_frame();
    logic [7:0] f[$];
    logic [11:0] flen;
    int m;
    bit drop;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_beat($urandom, 1'b0, $urandom_range(0, 1), $urandom);
    build_frame(f, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
    flen = f.size();
    drop = 0;
    m = $urandom_range(0, 99);
    if (m >= 70 && m < 80) begin
      f[$urandom_range(12, f.size() - 1)] = $urandom;
    end else if (m >= 80 && m < 88) begin
      f = f[0 : $urandom_range(0, f.size() - 1)];
      if ($urandom_range(0, 1) == 0) flen = f.size();
    end else if (m >= 88 && m < 94) begin
      flen = ($urandom_range(0, 3) == 0) ? 12'hFFF : $urandom_range(0, f.size() + 16);
    end else if (m >= 94) begin
      drop = 1;
    end
    play(f, flen, drop);
  endtask

  initial begin
    logic [7:0] f[$];
    logic [47:0] smac, fmac;
    sb = new();
    sb.errors = 0;
    sb.set_reg(RegStreamMac, 0); sb.set_reg(RegFilterMac, 0);
    sb.set_reg(RegFiltEn, 0); sb.set_reg(RegAnaEn, 0);
    sb.clear_frame();
    cycles = 0; burst_left = 0; sent_bytes = 0; hold_req = 0;
    in_valid_i = 0; in_data_i = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset configuration the analyzer is off: frames are ignored.
    build_frame(f, 1);
    play(f, f.size(), 0);
    drain();

    reg_write(RegStreamMac, 64'h0000_0A0B_0C0D_0E0F);
    reg_write(RegFilterMac, 64'h0000_0102_0304_0506);
    reg_write(RegFiltEn, 64'd0);
    reg_write(RegAnaEn, 64'd1);
    // A stray byte outside any frame, even one marked last, gives nothing.
    send_beat(8'hFF, 1'b0, 1'b1, 12'd0);
    // Zero ASDUs completes the frame at once.
    build_frame(f, 0);
    play(f, f.size(), 0);
    // A frame cut short inside the header.
    build_frame(f, 1);
    play(f[0:13], 12'd14, 0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      smac = (ph == 2) ? 48'hFFFF_FFFF_FFFF : (ph == 3) ? 48'h0 : {$urandom, $urandom};
      fmac = (ph == 4) ? 48'hFFFF_FFFF_FFFF : (ph == 5) ? 48'h0 : {$urandom, $urandom};
      reg_write(RegStreamMac, {16'h0, smac});
      reg_write(RegFilterMac, {16'h0, fmac});
      reg_write(RegFiltEn, {63'd0, ph[0]});
      reg_write(RegAnaEn, {63'd0, ph != 1});
      if (ph == 0) hold_req = 1;
      sent_bytes = 0;
      while (sent_bytes < 190) random_frame();
      drain();
    end

    repeat (20) @(posedge clk_i);
    sb.errors += sb.sample_q.size();
    if (sb.errors == 0) begin
      $display("tb_sampled_values_frame_parser_unit: clean");
    end else begin
      $display("tb_sampled_values_frame_parser_unit: errors");
    end
    $finish;
  end

endmodule
